// ===== design/pcm_fmt_pkg.sv =====
// Package for the PCM sample format converter.
// Holds format codes, register indexes, the config struct and decode helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcm_fmt_pkg;

    localparam int SampleWidth = 32;
    localparam int FmtWidth    = 3;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 3;

    // format codes
    localparam logic [FmtWidth-1:0] FMT_U8  = 3'd0;
    localparam logic [FmtWidth-1:0] FMT_S8  = 3'd1;
    localparam logic [FmtWidth-1:0] FMT_U16 = 3'd2;
    localparam logic [FmtWidth-1:0] FMT_S16 = 3'd3;
    localparam logic [FmtWidth-1:0] FMT_U32 = 3'd4;
    localparam logic [FmtWidth-1:0] FMT_S32 = 3'd5;

    // register indexes
    localparam logic [CfgIdxWidth-1:0] REG_SRC_FORMAT = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_DST_FORMAT = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_SRC_SWAP   = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_DST_SWAP   = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_DUP_MONO   = 3'd4;

    // width classes
    localparam logic [1:0] W8  = 2'd0;
    localparam logic [1:0] W16 = 2'd1;
    localparam logic [1:0] W32 = 2'd2;

    typedef struct packed {
        logic [FmtWidth-1:0] src_format;
        logic [FmtWidth-1:0] dst_format;
        logic                src_swap;
        logic                dst_swap;
        logic                dup_mono;
    } cfg_t;

    // codes 6 and 7 behave as s32
    function automatic logic [FmtWidth-1:0] fmt_clamp(input logic [FmtWidth-1:0] f);
        fmt_clamp = (f > FMT_S32) ? FMT_S32 : f;
    endfunction

    function automatic logic [1:0] fmt_class(input logic [FmtWidth-1:0] f);
        logic [FmtWidth-1:0] c;
        c = fmt_clamp(f);
        if (c < FMT_U16)
            fmt_class = W8;
        else if (c < FMT_U32)
            fmt_class = W16;
        else
            fmt_class = W32;
    endfunction

    function automatic logic fmt_unsigned(input logic [FmtWidth-1:0] f);
        logic [FmtWidth-1:0] c;
        c = fmt_clamp(f);
        fmt_unsigned = ~c[0];
    endfunction

endpackage

`default_nettype wire

// ===== design/pcm_fmt_if.sv =====
// Stream interfaces for the PCM sample format converter.
// Input word channel and result word channel; depends on pcm_fmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pcm_fmt_in_if;
    logic                                valid;
    logic                                ready;
    logic [pcm_fmt_pkg::SampleWidth-1:0] sample_in;
    logic                                block_end_in;

    modport source (output valid, output sample_in, output block_end_in, input ready);
    modport sink   (input valid, input sample_in, input block_end_in, output ready);
endinterface

interface pcm_fmt_out_if;
    logic                                valid;
    logic                                ready;
    logic [pcm_fmt_pkg::SampleWidth-1:0] sample_out;
    logic                                last_of_run;
    logic                                block_end_out;

    modport source (output valid, output sample_out, output last_of_run,
                    output block_end_out, input ready);
    modport sink   (input valid, input sample_out, input last_of_run,
                    input block_end_out, output ready);
endinterface

`default_nettype wire

// ===== design/pcm_fmt_conv.sv =====
// Combinational sample re-encoder for the PCM format converter.
// Depends on pcm_fmt_pkg (cfg_t, format decode helpers).
`timescale 1ns / 1ps
`default_nettype none

module pcm_fmt_conv (
    input  wire pcm_fmt_pkg::cfg_t                  cfg,
    input  wire [pcm_fmt_pkg::SampleWidth-1:0]      sample,
    output logic [pcm_fmt_pkg::SampleWidth-1:0]     result
);

    logic [1:0]  sw_cls;
    logic [1:0]  dw_cls;
    logic        s_uns;
    logic        d_uns;
    logic [31:0] x_mask;
    logic [31:0] x_swp;
    logic [31:0] frac;
    logic        rnd_up;
    logic        rnd_dn;
    logic [23:0] q;
    logic [31:0] r_raw;
    logic [31:0] r_swp;

    always_comb
    begin
        sw_cls = pcm_fmt_pkg::fmt_class(cfg.src_format);
        dw_cls = pcm_fmt_pkg::fmt_class(cfg.dst_format);
        s_uns  = pcm_fmt_pkg::fmt_unsigned(cfg.src_format);
        d_uns  = pcm_fmt_pkg::fmt_unsigned(cfg.dst_format);

        // keep source bits only, then swap and left-align with sign fix
        case (sw_cls)
            pcm_fmt_pkg::W8:  x_mask = {24'd0, sample[7:0]};
            pcm_fmt_pkg::W16: x_mask = {16'd0, sample[15:0]};
            default:          x_mask = sample;
        endcase

        x_swp = x_mask;
        if (cfg.src_swap)
        begin
            case (sw_cls)
                pcm_fmt_pkg::W16: x_swp = {16'd0, x_mask[7:0], x_mask[15:8]};
                pcm_fmt_pkg::W32: x_swp = {x_mask[7:0], x_mask[15:8],
                                           x_mask[23:16], x_mask[31:24]};
                default:          x_swp = x_mask;
            endcase
        end

        case (sw_cls)
            pcm_fmt_pkg::W8:  frac = {x_swp[7] ^ s_uns, x_swp[6:0], 24'd0};
            pcm_fmt_pkg::W16: frac = {x_swp[15] ^ s_uns, x_swp[14:0], 16'd0};
            default:          frac = {x_swp[31] ^ s_uns, x_swp[30:0]};
        endcase

        // Scaling by (2^23-1)/2^31 of an 8/16-bit fraction reduces to the top
        // 24 bits minus a correction of one: add one below -1/2, subtract one
        // above +1/2, and ties land on the even top word. Never saturates.
        rnd_up = frac[31] & ~frac[30];
        rnd_dn = ~frac[31] & frac[30] & (|frac[29:0]);
        if (rnd_up)
            q = frac[31:8] + 24'd1;
        else if (rnd_dn)
            q = frac[31:8] - 24'd1;
        else
            q = frac[31:8];

        if (dw_cls == pcm_fmt_pkg::W32 && sw_cls != pcm_fmt_pkg::W32)
            r_raw = {q[23] ^ d_uns, q[22:0], 8'd0};
        else
        begin
            case (dw_cls)
                pcm_fmt_pkg::W8:  r_raw = {24'd0, frac[31] ^ d_uns, frac[30:24]};
                pcm_fmt_pkg::W16: r_raw = {16'd0, frac[31] ^ d_uns, frac[30:16]};
                default:          r_raw = {frac[31] ^ d_uns, frac[30:0]};
            endcase
        end

        r_swp = r_raw;
        if (cfg.dst_swap)
        begin
            case (dw_cls)
                pcm_fmt_pkg::W16: r_swp = {16'd0, r_raw[7:0], r_raw[15:8]};
                pcm_fmt_pkg::W32: r_swp = {r_raw[7:0], r_raw[15:8],
                                           r_raw[23:16], r_raw[31:24]};
                default:          r_swp = r_raw;
            endcase
        end

        result = r_swp;
    end

endmodule

`default_nettype wire

// ===== design/pcm_sample_format_converter.sv =====
// Top level of the PCM sample format converter.
// Depends on pcm_fmt_pkg, pcm_fmt_in_if / pcm_fmt_out_if and pcm_fmt_conv.
`timescale 1ns / 1ps
`default_nettype none

// Re-encodes one PCM sample word between u8, s8, u16, s16, u32 and s32, with
// optional byte swap on either side and optional mono-to-stereo duplication.
// Words enter an input register, pass through the combinational converter
// pcm_fmt_conv and land in the result register. Without duplication one word
// is taken every cycle while the sink keeps ready high; with dup_mono set each
// input yields two result words, and the single result register must emit
// both copies before it loads the next word. The input side keeps accepting
// while a result waits, so a stalled sink holds at most two words inside.
// Write configuration only while the block is empty; format codes 6 and 7
// act as s32.
module pcm_sample_format_converter (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_we,
    input  wire [pcm_fmt_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  wire [pcm_fmt_pkg::CfgDataWidth-1:0]   cfg_data,
    pcm_fmt_in_if.sink                            in_ch,
    pcm_fmt_out_if.source                         out_ch
);

    // configuration registers
    pcm_fmt_pkg::cfg_t cfg_reg;

    // input register
    logic                                s1_valid_reg;
    logic [pcm_fmt_pkg::SampleWidth-1:0] s1_sample_reg;
    logic                                s1_bend_reg;

    // result register; first_reg marks the first copy of a duplicated pair
    logic                                out_valid_reg;
    logic                                out_first_reg;
    logic [pcm_fmt_pkg::SampleWidth-1:0] out_sample_reg;
    logic                                out_bend_reg;

    logic [pcm_fmt_pkg::SampleWidth-1:0] conv_result;
    logic                                out_take;
    logic                                out_free;
    logic                                s1_adv;
    logic                                in_take;

    // register writes; out-of-range indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_format <= pcm_fmt_pkg::FMT_S16;
            cfg_reg.dst_format <= pcm_fmt_pkg::FMT_S16;
            cfg_reg.src_swap   <= 1'b0;
            cfg_reg.dst_swap   <= 1'b0;
            cfg_reg.dup_mono   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcm_fmt_pkg::REG_SRC_FORMAT: cfg_reg.src_format <= cfg_data;
                pcm_fmt_pkg::REG_DST_FORMAT: cfg_reg.dst_format <= cfg_data;
                pcm_fmt_pkg::REG_SRC_SWAP:   cfg_reg.src_swap   <= cfg_data[0];
                pcm_fmt_pkg::REG_DST_SWAP:   cfg_reg.dst_swap   <= cfg_data[0];
                pcm_fmt_pkg::REG_DUP_MONO:   cfg_reg.dup_mono   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: the result register frees up when empty or when its final
    // copy is taken; the input register advances into it then, and takes a
    // new word whenever it is empty or advancing.
    assign out_take = out_valid_reg & out_ch.ready;
    assign out_free = ~out_valid_reg | (out_ch.ready & ~out_first_reg);
    assign s1_adv   = s1_valid_reg & out_free;
    assign in_ch.ready = ~s1_valid_reg | out_free;
    assign in_take  = in_ch.valid & in_ch.ready;

    // hold the input word until the result register can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= in_ch.sample_in;
            s1_bend_reg   <= in_ch.block_end_in;
        end
    end

    pcm_fmt_conv u_conv (
        .cfg    (cfg_reg),
        .sample (s1_sample_reg),
        .result (conv_result)
    );

    // result register control: load on advance, step from first to second
    // copy on a take, drop once the final copy is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_first_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
            out_first_reg <= cfg_reg.dup_mono;
        end
        else if (out_take)
        begin
            if (out_first_reg)
                out_first_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_sample_reg <= conv_result;
            out_bend_reg   <= s1_bend_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.sample_out    = out_sample_reg;
    assign out_ch.last_of_run   = ~out_first_reg;
    assign out_ch.block_end_out = out_bend_reg & ~out_first_reg;

`ifndef ASSERT_OFF
    // the first copy of a pair never carries the buffer end mark
    a_first_no_bend: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.last_of_run |-> !out_ch.block_end_out)
        else $error("first copy of a pair carries block end");

    // taking the first copy leaves the second copy showing next cycle
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.last_of_run
        |=> out_ch.valid && out_ch.last_of_run)
        else $error("second copy of a pair missing");

    // both copies of a pair carry the same sample
    a_pair_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.last_of_run
        |=> out_ch.sample_out == $past(out_ch.sample_out))
        else $error("copies of a pair differ");

    // a held input word is never overwritten
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_sample_reg))
        else $error("input register lost a word");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for pcm_sample_format_converter.
// Depends on pcm_fmt_pkg and the stream interfaces in pcm_fmt_if.sv.
// Drives words with random gaps and stalls and checks every result word.
`timescale 1ns / 1ps

module tb;
    import pcm_fmt_pkg::*;

    // Codes 6 and 7 are not formats of their own; the block treats them as s32.
    localparam logic [FmtWidth-1:0] FMT_ALIAS_6 = 3'd6;
    localparam logic [FmtWidth-1:0] FMT_ALIAS_7 = 3'd7;
    // Lowest register index with no register behind it.
    localparam logic [CfgIdxWidth-1:0] REG_UNUSED = 3'd5;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int WORDS_PER_PHASE = 25;

    localparam logic [FmtWidth-1:0] FORMATS [6] =
        '{FMT_U8, FMT_S8, FMT_U16, FMT_S16, FMT_U32, FMT_S32};

    // Predicts result words from the register copy and checks them in order.
    class format_scoreboard;
        typedef struct {
            logic [31:0] sample;
            logic        last;
            logic        bend;
        } word_t;

        logic [FmtWidth-1:0] src_fmt;
        logic [FmtWidth-1:0] dst_fmt;
        bit                  src_swap;
        bit                  dst_swap;
        bit                  dup_mono;
        word_t               expected_words [$];
        int                  failures;

        function new();
            src_fmt  = FMT_S16;
            dst_fmt  = FMT_S16;
            src_swap = 1'b0;
            dst_swap = 1'b0;
            dup_mono = 1'b0;
            failures = 0;
        endfunction

        function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
            case (idx)
                REG_SRC_FORMAT: src_fmt = data;
                REG_DST_FORMAT: dst_fmt = data;
                REG_SRC_SWAP:   src_swap = data[0];
                REG_DST_SWAP:   dst_swap = data[0];
                REG_DUP_MONO:   dup_mono = data[0];
                default: ;
            endcase
        endfunction

        function logic [FmtWidth-1:0] effective(logic [FmtWidth-1:0] f);
            return (f > FMT_S32) ? FMT_S32 : f;
        endfunction

        function int bits_of(logic [FmtWidth-1:0] f);
            if (f < FMT_U16)
                return 8;
            if (f < FMT_U32)
                return 16;
            return 32;
        endfunction

        function logic [31:0] mask_to(int w);
            return (w == 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
        endfunction

        function logic [31:0] swap_bytes(logic [31:0] x, int w);
            if (w == 16)
                return {16'h0, x[7:0], x[15:8]};
            if (w == 32)
                return {x[7:0], x[15:8], x[23:16], x[31:24]};
            return x;
        endfunction

        // Q1.31 fraction times 8388607, round half to even, clamp to 24 bits.
        function logic [31:0] scale_q31(logic [31:0] frac, bit uns);
            longint      prod;
            logic [63:0] biased;
            logic [30:0] rem;
            longint      q;
            logic [23:0] top;
            prod   = longint'(signed'(frac)) * 64'sd8388607;
            biased = prod + (64'sd1 <<< 55);
            rem    = biased[30:0];
            q      = longint'(biased >> 31) - (64'sd1 <<< 24);
            if (rem > 31'h4000_0000 || (rem == 31'h4000_0000 && q[0]))
                q = q + 1;
            if (q > (64'sd1 <<< 23) - 1)
                q = (64'sd1 <<< 23) - 1;
            if (q < -(64'sd1 <<< 23))
                q = -(64'sd1 <<< 23);
            if (uns)
                q = q + (64'sd1 <<< 23);
            top = q[23:0];
            return {top, 8'h00};
        endfunction

        function void note_input(logic [31:0] raw, logic bend);
            logic [FmtWidth-1:0] sf;
            logic [FmtWidth-1:0] df;
            int                  sw;
            int                  dw;
            logic [31:0]         x;
            logic [31:0]         frac;
            logic [31:0]         r;
            sf = effective(src_fmt);
            df = effective(dst_fmt);
            sw = bits_of(sf);
            dw = bits_of(df);
            x  = raw & mask_to(sw);
            if (src_swap)
                x = swap_bytes(x, sw);
            if (!sf[0])
                x = x ^ (32'h1 << (sw - 1));
            frac = x << (32 - sw);
            if (dw == 32 && sw != 32)
                r = scale_q31(frac, !df[0]);
            else
            begin
                r = (dw == 32) ? frac : (frac >> (32 - dw));
                if (!df[0])
                    r = r ^ (32'h1 << (dw - 1));
            end
            r = r & mask_to(dw);
            if (dst_swap)
                r = swap_bytes(r, dw);
            if (dup_mono)
                expected_words.push_back('{r, 1'b0, 1'b0});
            expected_words.push_back('{r, 1'b1, bend});
        endfunction

        function void check_result(logic [31:0] sample, logic last, logic bend);
            word_t w;
            if (expected_words.size() == 0)
            begin
                $error("result word %h with nothing expected", sample);
                failures++;
                return;
            end
            w = expected_words.pop_front();
            if (sample !== w.sample)
            begin
                $error("sample_out expected %h got %h", w.sample, sample);
                failures++;
            end
            if (last !== w.last)
            begin
                $error("last_of_run expected %b got %b", w.last, last);
                failures++;
            end
            if (bend !== w.bend)
            begin
                $error("block_end_out expected %b got %b", w.bend, bend);
                failures++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    pcm_fmt_in_if  in_ch ();
    pcm_fmt_out_if out_ch ();

    pcm_sample_format_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    format_scoreboard sb = new();

    // steady: no idling on either side. hold_request: ask the sink for a long hold-off.
    bit steady;
    bit hold_request;
    int hold_left;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Sink side: drop ready at random, or hold it low for a long stretch on request
    // so the block fills up and has to stall its input.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end
        else if (steady)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(99) >= 27);
    end

    // Check every accepted result word. Values are read before the edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.sample_out, out_ch.last_of_run, out_ch.block_end_out);
    end

    // Watchdog: count cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one word, with random idle cycles ahead of it unless the stream is steady.
    // Hold valid high across back-to-back words; note the word once it is taken.
    task automatic send_word(input logic [31:0] s, input logic bend);
        while (!steady && $urandom_range(99) < 27)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.sample_in    <= $urandom;
            in_ch.block_end_in <= $urandom_range(1);
            @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_in    <= s;
        in_ch.block_end_in <= bend;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_input(s, bend);
        @(negedge clk);
    endtask

    // Write one register; the write lands on the next rising edge.
    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Program all five registers. Flag bits ride with random upper data bits,
    // which the block must ignore; optionally add a write to an unused index.
    task automatic apply_config(input logic [FmtWidth-1:0] sf, input logic [FmtWidth-1:0] df,
                                input bit ssw, input bit dsw, input bit dup,
                                input bit stray);
        write_reg(REG_SRC_FORMAT, sf);
        write_reg(REG_DST_FORMAT, df);
        write_reg(REG_SRC_SWAP, {2'($urandom), ssw});
        write_reg(REG_DST_SWAP, {2'($urandom), dsw});
        write_reg(REG_DUP_MONO, {2'($urandom), dup});
        if (stray)
            write_reg(REG_UNUSED + 3'($urandom_range(2)), 3'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Stop offering, wait for every expected word, then let the pipeline settle.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Mostly random words; the rest pin the low 8, 16 or 32 bits to an extreme
    // under random upper bits.
    function automatic logic [31:0] pick_sample();
        logic [31:0] v;
        logic [31:0] m;
        int          w;
        v = $urandom;
        if ($urandom_range(3) != 0)
            return v;
        w = 8 << $urandom_range(2);
        m = (w == 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
        case ($urandom_range(3))
            0:       v = v & ~m;
            1:       v = v | m;
            2:       v = (v & ~m) | (32'h1 << (w - 1));
            default: v = (v & ~m) | (m >> 1);
        endcase
        return v;
    endfunction

    initial
    begin
        logic [FmtWidth-1:0] sf;
        logic [FmtWidth-1:0] df;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.sample_in    = '0;
        in_ch.block_end_in = 1'b0;
        out_ch.ready       = 1'b0;
        steady             = 1'b0;
        hold_request       = 1'b0;
        hold_left          = 0;
        quiet_cycles       = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting, s16 to s16: pass through, upper garbage dropped.
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_8000, 1'b0);
        send_word(32'hDEAD_7FFF, 1'b1);
        drain_block();

        // u8 to s32 through the scaler, duplicated; swaps have no effect on bytes
        // at the source and swap the whole word at the destination.
        apply_config(FMT_U8, FMT_S32, 1'b1, 1'b1, 1'b1, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0080, 1'b1);
        send_word(32'h1234_567F, 1'b0);
        drain_block();

        // Alias codes act as s32; stray writes to unused indexes are ignored.
        apply_config(FMT_ALIAS_7, FMT_U8, 1'b0, 1'b0, 1'b0, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        send_word(32'h1234_5678, 1'b0);
        drain_block();

        // s16 to u32 with both swaps: the most negative sample after the swap.
        apply_config(FMT_S16, FMT_U32, 1'b1, 1'b1, 1'b0, 1'b0);
        send_word(32'h0000_0080, 1'b0);
        send_word(32'h0000_FF7F, 1'b1);
        send_word(32'hFFFF_0000, 1'b0);
        drain_block();

        // Same width, other signedness: swap the source bytes and flip the top bit.
        apply_config(FMT_U32, FMT_ALIAS_6, 1'b1, 1'b0, 1'b1, 1'b0);
        send_word(32'h0000_0080, 1'b1);
        send_word(32'hFFFF_FF7F, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        drain_block();

        // Random part: walk every source/destination pair with random swaps and
        // duplication. Hold the sink off twice and run three phases with no idling.
        for (int p = 0; p < 36; p++)
        begin
            sf = FORMATS[p / 6];
            df = FORMATS[p % 6];
            if (sf == FMT_S32 && $urandom_range(2) == 0)
                sf = $urandom_range(1) ? FMT_ALIAS_6 : FMT_ALIAS_7;
            if (df == FMT_S32 && $urandom_range(2) == 0)
                df = $urandom_range(1) ? FMT_ALIAS_6 : FMT_ALIAS_7;
            apply_config(sf, df, $urandom_range(1), $urandom_range(1), $urandom_range(1),
                         (p % 9) == 4);
            steady = (p >= 12 && p <= 14);
            if (p == 4 || p == 23)
                hold_request = 1'b1;
            for (int i = 0; i < WORDS_PER_PHASE; i++)
                send_word(pick_sample(), $urandom_range(7) == 0);
            drain_block();
            steady = 1'b0;
        end

        repeat (10) @(negedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
